[rtl/ptfs_pkg.sv]
// ----------------------------------------------------------------------------
// ptfs_pkg
// shared types, codes and the 2^(-j/16) table of the peak table field sampler
// ----------------------------------------------------------------------------
package ptfs_pkg;

  localparam int DIM   = 2;
  localparam int ACC_W = 42;

  typedef enum logic [1:0] {
    ACT_ADD     = 2'd0,
    ACT_KILL    = 2'd1,
    ACT_RESTORE = 2'd2,
    ACT_SAMPLE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    DIV_DIM0 = 2'd0,
    DIV_DIM1 = 2'd1,
    DIV_LOR  = 2'd2
  } div_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UPD,
    S_SCAN,
    S_LOAD0,
    S_DIV0,
    S_LOAD1,
    S_DIV1,
    S_EXP,
    S_DIVL,
    S_MIX,
    S_ACC,
    S_FIN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic     load;
    logic     upd;
    logic     inc_idx;
    logic     div_start;
    div_sel_t div_sel;
    logic     sq0;
    logic     sq1;
    logic     exp_ld;
    logic     mix_ld;
    logic     acc_ld;
    logic     fin_ld;
  } cmd_t;

  typedef struct packed {
    action_t action;
    logic    idx_end;
    logic    cur_active;
    logic    div_busy;
  } status_t;

  function automatic logic [16:0] pow2_tab(input logic [4:0] j);
    logic [16:0] v;
    case (j)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd62757;
      5'd2:    v = 17'd60097;
      5'd3:    v = 17'd57549;
      5'd4:    v = 17'd55109;
      5'd5:    v = 17'd52773;
      5'd6:    v = 17'd50535;
      5'd7:    v = 17'd48393;
      5'd8:    v = 17'd46341;
      5'd9:    v = 17'd44376;
      5'd10:   v = 17'd42495;
      5'd11:   v = 17'd40693;
      5'd12:   v = 17'd38968;
      5'd13:   v = 17'd37316;
      5'd14:   v = 17'd35734;
      5'd15:   v = 17'd34219;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

endpackage

[rtl/peak_table_field_sampler_core.sv]
// add, deactivate and reactivate go through the update state to the result beat
// a sample scans the slots up to the peak count, skips inactive ones and for each
// active peak runs the bit-serial divider twice for distance and once for 1/(4s+1)
// one item at a time; the next beat is taken after the result beat leaves
// rst clears the peak count and all active flags; table contents need no reset
module peak_table_field_sampler_core #(
  parameter int NPEAKS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // coord_a, coord_b, width_a, width_b, peak_height, mix_weight, peak_index, pad
  input  logic [95:0] s_tdata,
  // action
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // field_value, accepted, saturated, pad
  output logic [39:0] m_tdata
);

  ptfs_pkg::cmd_t    cmd;
  ptfs_pkg::status_t sts;

  ptfs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ptfs_dp #(
    .NPEAKS (NPEAKS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .cmd     (cmd),
    .sts     (sts),
    .m_tdata (m_tdata)
  );

endmodule

[rtl/ptfs_ctrl.sv]
// ----------------------------------------------------------------------------
// ptfs_ctrl
// sequencer: table updates and the per-peak sample walk
// ----------------------------------------------------------------------------
module ptfs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  ptfs_pkg::status_t sts,
  output ptfs_pkg::cmd_t    cmd
);

  ptfs_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ptfs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ptfs_pkg::S_IDLE: begin
        if (s_tvalid) state_next = ptfs_pkg::S_UPD;
      end
      ptfs_pkg::S_UPD: begin
        if (sts.action == ptfs_pkg::ACT_SAMPLE) state_next = ptfs_pkg::S_SCAN;
        else state_next = ptfs_pkg::S_DONE;
      end
      ptfs_pkg::S_SCAN: begin
        if (sts.idx_end) state_next = ptfs_pkg::S_FIN;
        else if (sts.cur_active) state_next = ptfs_pkg::S_LOAD0;
      end
      ptfs_pkg::S_LOAD0: state_next = ptfs_pkg::S_DIV0;
      ptfs_pkg::S_DIV0: begin
        if (!sts.div_busy) state_next = ptfs_pkg::S_LOAD1;
      end
      ptfs_pkg::S_LOAD1: state_next = ptfs_pkg::S_DIV1;
      ptfs_pkg::S_DIV1: begin
        if (!sts.div_busy) state_next = ptfs_pkg::S_EXP;
      end
      ptfs_pkg::S_EXP:  state_next = ptfs_pkg::S_DIVL;
      ptfs_pkg::S_DIVL: begin
        if (!sts.div_busy) state_next = ptfs_pkg::S_MIX;
      end
      ptfs_pkg::S_MIX:  state_next = ptfs_pkg::S_ACC;
      ptfs_pkg::S_ACC:  state_next = ptfs_pkg::S_SCAN;
      ptfs_pkg::S_FIN:  state_next = ptfs_pkg::S_DONE;
      ptfs_pkg::S_DONE: begin
        if (m_tready) state_next = ptfs_pkg::S_IDLE;
      end
      default: state_next = ptfs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.div_sel  = ptfs_pkg::DIV_DIM0;
    s_tready     = 1'b0;
    m_tvalid     = 1'b0;
    unique case (state)
      ptfs_pkg::S_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      ptfs_pkg::S_UPD: cmd.upd = 1'b1;
      ptfs_pkg::S_SCAN: begin
        cmd.inc_idx = !sts.idx_end && !sts.cur_active;
      end
      ptfs_pkg::S_LOAD0: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = ptfs_pkg::DIV_DIM0;
      end
      ptfs_pkg::S_DIV0: cmd.sq0 = !sts.div_busy;
      ptfs_pkg::S_LOAD1: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = ptfs_pkg::DIV_DIM1;
      end
      ptfs_pkg::S_DIV1: cmd.sq1 = !sts.div_busy;
      ptfs_pkg::S_EXP:  cmd.exp_ld = 1'b1;
      ptfs_pkg::S_DIVL: begin
        if (!sts.div_busy) cmd.mix_ld = 1'b0;
      end
      ptfs_pkg::S_MIX: cmd.mix_ld = 1'b1;
      ptfs_pkg::S_ACC: begin
        cmd.acc_ld  = 1'b1;
        cmd.inc_idx = 1'b1;
      end
      ptfs_pkg::S_FIN:  cmd.fin_ld = 1'b1;
      ptfs_pkg::S_DONE: m_tvalid = 1'b1;
      default: ;
    endcase
    if (state == ptfs_pkg::S_EXP) begin
      cmd.div_start = 1'b1;
      cmd.div_sel   = ptfs_pkg::DIV_LOR;
    end
  end

endmodule

[rtl/ptfs_dp.sv]
// ----------------------------------------------------------------------------
// ptfs_dp
// peak table storage, shared serial divider and the pseudo-voigt datapath
// ----------------------------------------------------------------------------
module ptfs_dp #(
  parameter int NPEAKS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [95:0]       s_tdata,
  input  logic [1:0]        s_tuser,
  input  ptfs_pkg::cmd_t    cmd,
  output ptfs_pkg::status_t sts,
  output logic [39:0]       m_tdata
);

  localparam int AW   = (NPEAKS > 1) ? $clog2(NPEAKS) : 1;
  localparam int CW   = $clog2(NPEAKS + 1);
  localparam int CMPW = (CW > 4) ? CW : 4;

  // latched item
  ptfs_pkg::action_t  action;
  logic signed [15:0] pt_a, pt_b, hgt_in;
  logic [15:0]        wa_in, wb_in;
  logic [8:0]         mix_in;
  logic [3:0]         idx_in;

  // table
  logic signed [15:0] ctr_a_mem [NPEAKS];
  logic signed [15:0] ctr_b_mem [NPEAKS];
  logic [15:0]        wid_a_mem [NPEAKS];
  logic [15:0]        wid_b_mem [NPEAKS];
  logic signed [15:0] hgt_mem   [NPEAKS];
  logic [8:0]         mix_mem   [NPEAKS];
  logic signed [15:0] ctr_a_rd, ctr_b_rd, hgt_rd;
  logic [15:0]        wid_a_rd, wid_b_rd;
  logic [8:0]         mix_rd;
  logic [NPEAKS-1:0]  active;
  logic [CW-1:0]      count;
  logic [CW-1:0]      idx;

  // divider
  logic [35:0] dv_rem;
  logic [34:0] dv_den;
  logic [23:0] dv_num, dv_quo;
  logic [4:0]  dv_cnt;
  logic        dv_busy;

  // arithmetic
  logic [31:0]              s_acc;
  logic [34:0]              t_reg;
  logic [16:0]              g_reg, p_reg;
  logic signed [ptfs_pkg::ACC_W-1:0] acc;
  logic signed [31:0]       res_value;
  logic                     res_acc, res_sat;

  logic signed [9:0]  mix_raw;
  logic [8:0]         mix_clamped;
  logic [CMPW-1:0]    idx_cmp, count_cmp;
  logic               idx_ok, cur_active;
  logic signed [16:0] diff0, diff1;
  logic [15:0]        mag0, mag1, mag_sel, w_sel;
  logic [23:0]        u_fin;
  logic [47:0]        u_sq;
  logic [31:0]        term;
  logic [32:0]        s_sum;
  logic [34:0]        d_lor, n_lor;
  logic [35:0]        dv_try;
  logic [50:0]        t_prod;
  logic [18:0]        g_n;
  logic [3:0]         g_j;
  logic [11:0]        g_r;
  logic [16:0]        g_a, g_b, g_v;
  logic [28:0]        g_lin;
  logic [25:0]        p_l, p_g;
  logic [26:0]        p_sum;
  logic signed [33:0] h_prod;
  logic signed [ptfs_pkg::ACC_W-1:0] q_round, r_shift;

  assign mix_raw     = s_tdata[89:80];
  assign mix_clamped = mix_raw[9] ? 9'd0 :
                       (mix_raw > 10'sd256) ? 9'd256 : mix_raw[8:0];

  assign idx_cmp   = CMPW'(idx_in);
  assign count_cmp = CMPW'(count);
  assign idx_ok    = idx_cmp < count_cmp;

  always_comb begin
    cur_active = 1'b0;
    for (int k = 0; k < NPEAKS; k++) begin
      if (idx == CW'(k)) cur_active = active[k];
    end
  end

  assign sts.action     = action;
  assign sts.idx_end    = (idx == count);
  assign sts.cur_active = cur_active;
  assign sts.div_busy   = dv_busy;

  // input latch and table updates
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action <= ptfs_pkg::action_t'(s_tuser);
      pt_a   <= s_tdata[15:0];
      pt_b   <= s_tdata[31:16];
      wa_in  <= s_tdata[47:32];
      wb_in  <= s_tdata[63:48];
      hgt_in <= s_tdata[79:64];
      mix_in <= mix_clamped;
      idx_in <= s_tdata[93:90];
    end
    if (cmd.upd && action == ptfs_pkg::ACT_ADD && count != CW'(NPEAKS)) begin
      ctr_a_mem[count[AW-1:0]] <= pt_a;
      ctr_b_mem[count[AW-1:0]] <= pt_b;
      wid_a_mem[count[AW-1:0]] <= wa_in;
      wid_b_mem[count[AW-1:0]] <= wb_in;
      hgt_mem[count[AW-1:0]]   <= hgt_in;
      mix_mem[count[AW-1:0]]   <= mix_in;
    end
    ctr_a_rd <= ctr_a_mem[idx[AW-1:0]];
    ctr_b_rd <= ctr_b_mem[idx[AW-1:0]];
    wid_a_rd <= wid_a_mem[idx[AW-1:0]];
    wid_b_rd <= wid_b_mem[idx[AW-1:0]];
    hgt_rd   <= hgt_mem[idx[AW-1:0]];
    mix_rd   <= mix_mem[idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
      count  <= '0;
      idx    <= '0;
    end else begin
      if (cmd.load) idx <= '0;
      else if (cmd.inc_idx) idx <= idx + CW'(1);
      if (cmd.upd) begin
        unique case (action)
          ptfs_pkg::ACT_ADD: begin
            if (count != CW'(NPEAKS)) begin
              for (int k = 0; k < NPEAKS; k++) begin
                if (count == CW'(k)) active[k] <= 1'b1;
              end
              count <= count + CW'(1);
            end
          end
          ptfs_pkg::ACT_KILL, ptfs_pkg::ACT_RESTORE: begin
            for (int k = 0; k < NPEAKS; k++) begin
              if (idx_ok && idx_cmp == CMPW'(k)) begin
                active[k] <= (action == ptfs_pkg::ACT_RESTORE);
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  // normalized distance per dimension
  assign diff0 = {ctr_a_rd[15], ctr_a_rd} - {pt_a[15], pt_a};
  assign diff1 = {ctr_b_rd[15], ctr_b_rd} - {pt_b[15], pt_b};
  assign mag0  = diff0[16] ? 16'(-diff0) : diff0[15:0];
  assign mag1  = diff1[16] ? 16'(-diff1) : diff1[15:0];
  assign mag_sel = cmd.sq1 ? mag1 : mag0;
  assign w_sel   = cmd.sq1 ? wid_b_rd : wid_a_rd;

  always_comb begin
    if (mag_sel == 16'd0) u_fin = '0;
    else if ({8'd0, mag_sel} >= {w_sel, 8'd0}) u_fin = 24'hFFFFFF;
    else u_fin = dv_quo;
  end

  assign u_sq  = u_fin * u_fin;
  assign term  = 32'((u_sq + 48'd32768) >> 16);
  assign s_sum = {1'b0, s_acc} + {1'b0, term};

  // lorentzian numerator and denominator
  assign d_lor = {1'b0, s_acc, 2'b00} + 35'd65536;
  assign n_lor = 35'h1_0000_0000 + {1'b0, d_lor[34:1]};

  // shared restoring divider, one quotient bit a cycle
  assign dv_try = {dv_rem[34:0], dv_num[23]};

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_busy <= 1'b0;
      dv_cnt  <= '0;
    end else if (cmd.div_start) begin
      dv_busy <= 1'b1;
      dv_quo  <= '0;
      unique case (cmd.div_sel)
        ptfs_pkg::DIV_DIM0: begin
          dv_rem <= {28'd0, mag0[15:8]};
          dv_num <= {mag0[7:0], 16'd0};
          dv_den <= {19'd0, wid_a_rd};
          dv_cnt <= 5'd24;
        end
        ptfs_pkg::DIV_DIM1: begin
          dv_rem <= {28'd0, mag1[15:8]};
          dv_num <= {mag1[7:0], 16'd0};
          dv_den <= {19'd0, wid_b_rd};
          dv_cnt <= 5'd24;
        end
        default: begin
          dv_rem <= {18'd0, n_lor[34:17]};
          dv_num <= {n_lor[16:0], 7'd0};
          dv_den <= d_lor;
          dv_cnt <= 5'd17;
        end
      endcase
    end else if (dv_busy) begin
      if (dv_try >= {1'b0, dv_den}) begin
        dv_rem <= dv_try - {1'b0, dv_den};
        dv_quo <= {dv_quo[22:0], 1'b1};
      end else begin
        dv_rem <= dv_try;
        dv_quo <= {dv_quo[22:0], 1'b0};
      end
      dv_num <= {dv_num[22:0], 1'b0};
      dv_cnt <= dv_cnt - 5'd1;
      if (dv_cnt == 5'd1) dv_busy <= 1'b0;
    end
  end

  // gaussian by 2^-x table with linear interpolation
  assign t_prod = s_acc * 19'd262183 + 51'd32768;
  assign g_n    = t_reg[34:16];
  assign g_j    = t_reg[15:12];
  assign g_r    = t_reg[11:0];
  assign g_a    = ptfs_pkg::pow2_tab({1'b0, g_j});
  assign g_b    = ptfs_pkg::pow2_tab({1'b0, g_j} + 5'd1);
  assign g_lin  = (g_a - g_b) * g_r + 29'd2048;
  assign g_v    = g_a - 17'(g_lin >> 12);

  // mix and weight
  assign p_l    = mix_rd * dv_quo[16:0];
  assign p_g    = (9'd256 - mix_rd) * g_reg;
  assign p_sum  = {1'b0, p_l} + {1'b0, p_g} + 27'd128;
  assign h_prod = hgt_rd * $signed({1'b0, p_reg});

  assign q_round = acc + ptfs_pkg::ACC_W'(128);
  assign r_shift = q_round >>> 8;

  always_ff @(posedge clk) begin
    if (cmd.sq0) s_acc <= term;
    if (cmd.sq1) s_acc <= s_sum[32] ? 32'hFFFFFFFF : s_sum[31:0];
    if (cmd.exp_ld) t_reg <= t_prod[50:16];
    g_reg <= (g_n > 19'd16) ? 17'd0 : (g_v >> g_n[4:0]);
    if (cmd.mix_ld) p_reg <= p_sum[24:8];
    if (cmd.load) acc <= '0;
    else if (cmd.acc_ld) acc <= acc + ptfs_pkg::ACC_W'(h_prod);
    if (cmd.upd) begin
      res_value <= '0;
      res_sat   <= 1'b0;
      unique case (action)
        ptfs_pkg::ACT_ADD:    res_acc <= (count != CW'(NPEAKS));
        ptfs_pkg::ACT_KILL, ptfs_pkg::ACT_RESTORE: res_acc <= idx_ok;
        default:              res_acc <= 1'b0;
      endcase
    end
    if (cmd.fin_ld) begin
      if (r_shift > ptfs_pkg::ACC_W'(64'sd2147483647)) begin
        res_value <= 32'h7FFFFFFF;
        res_sat   <= 1'b1;
      end else if (r_shift < -ptfs_pkg::ACC_W'(64'sd2147483648)) begin
        res_value <= 32'h80000000;
        res_sat   <= 1'b1;
      end else begin
        res_value <= r_shift[31:0];
        res_sat   <= 1'b0;
      end
    end
  end

  assign m_tdata = {6'd0, res_sat, res_acc, res_value};

endmodule

[verif/peak_field_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// peak_field_checker
// watches both streams, keeps its own peak table and compares every result
// beat against the predicted field value and flags
// ----------------------------------------------------------------------------
module peak_field_checker #(
  parameter int NPEAKS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [95:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [31:0] value;
    logic        accepted;
    logic        saturated;
  } field_result_t;

  logic signed [15:0] ctr_a [NPEAKS];
  logic signed [15:0] ctr_b [NPEAKS];
  logic [15:0]        wid_a [NPEAKS];
  logic [15:0]        wid_b [NPEAKS];
  logic signed [15:0] hgt   [NPEAKS];
  logic [8:0]         mixw  [NPEAKS];
  logic               live  [NPEAKS];
  int                 npk;
  field_result_t      expected_results [$];

  function automatic longint unsigned pow2_entry(input longint unsigned j);
    longint unsigned t [17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535,
                                48393, 46341, 44376, 42495, 40693, 38968, 37316,
                                35734, 34219, 32768};
    return t[j];
  endfunction

  function automatic longint unsigned norm_sq(input logic signed [15:0] p,
                                              input logic signed [15:0] c,
                                              input logic [15:0] w);
    longint signed diff;
    longint unsigned mag, u;
    diff = longint'(p) - longint'(c);
    mag = diff < 0 ? -diff : diff;
    if (mag == 0) u = 0;
    else if (w == 0) u = 64'hFFFFFF;
    else begin
      u = (mag << 16) / w;
      if (u > 64'hFFFFFF) u = 64'hFFFFFF;
    end
    return (u * u + 32768) >> 16;
  endfunction

  function automatic field_result_t sample_field(input logic signed [15:0] pa,
                                                 input logic signed [15:0] pb);
    field_result_t res;
    longint signed sum, q, r;
    longint unsigned s, t, n, f, j, rr, a, b, v, g, d, l, p;
    sum = 0;
    for (int i = 0; i < npk; i++) begin
      if (!live[i]) continue;
      s = norm_sq(pa, ctr_a[i], wid_a[i]);
      if (s > 64'hFFFFFFFF) s = 64'hFFFFFFFF;
      s += norm_sq(pb, ctr_b[i], wid_b[i]);
      if (s > 64'hFFFFFFFF) s = 64'hFFFFFFFF;
      t = (s * 262183 + 32768) >> 16;
      n = t >> 16;
      f = t & 16'hFFFF;
      if (n > 16) g = 0;
      else begin
        j = f >> 12;
        rr = f & 12'hFFF;
        a = pow2_entry(j);
        b = pow2_entry(j + 1);
        v = a - (((a - b) * rr + 2048) >> 12);
        g = v >> n;
      end
      d = 4 * s + 65536;
      l = ((64'd1 << 32) + d / 2) / d;
      p = (mixw[i] * l + (256 - mixw[i]) * g + 128) >> 8;
      sum += longint'(hgt[i]) * longint'(p);
    end
    q = sum + 128;
    if (q >= 0) r = q / 256;
    else r = -((-q + 255) / 256);
    res = '0;
    if (r > 64'sd2147483647) begin
      r = 64'sd2147483647;
      res.saturated = 1'b1;
    end
    if (r < -64'sd2147483648) begin
      r = -64'sd2147483648;
      res.saturated = 1'b1;
    end
    res.value = r[31:0];
    return res;
  endfunction

  function automatic field_result_t apply_beat(input ptfs_pkg::action_t act,
                                               input logic [95:0] d);
    field_result_t res;
    logic signed [9:0] m;
    int idx;
    res = '0;
    idx = d[93:90];
    case (act)
      ptfs_pkg::ACT_ADD: begin
        if (npk < NPEAKS) begin
          m = d[89:80];
          ctr_a[npk] = d[15:0];
          ctr_b[npk] = d[31:16];
          wid_a[npk] = d[47:32];
          wid_b[npk] = d[63:48];
          hgt[npk]   = d[79:64];
          mixw[npk]  = m < 0 ? 9'd0 : (m > 256 ? 9'd256 : m[8:0]);
          live[npk]  = 1'b1;
          npk++;
          res.accepted = 1'b1;
        end
      end
      ptfs_pkg::ACT_KILL, ptfs_pkg::ACT_RESTORE: begin
        if (idx < npk) begin
          live[idx] = (act == ptfs_pkg::ACT_RESTORE);
          res.accepted = 1'b1;
        end
      end
      default: res = sample_field(d[15:0], d[31:16]);
    endcase
    return res;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    field_result_t got, exp_r;
    if (rst) begin
      npk <= 0;
      fail_count <= 0;
      for (int i = 0; i < NPEAKS; i++) live[i] = 1'b0;
      expected_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.value = m_tdata[31:0];
        got.accepted = m_tdata[32];
        got.saturated = m_tdata[33];
        if (expected_results.size() == 0) begin
          $display("%0t: result beat with none expected, actual %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (got !== exp_r) begin
            $display("%0t: mismatch value/acc/sat expected %h %b %b actual %h %b %b",
                     $time, exp_r.value, exp_r.accepted, exp_r.saturated,
                     got.value, got.accepted, got.saturated);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (s_tvalid && s_tready)
        expected_results.push_back(apply_beat(ptfs_pkg::action_t'(s_tuser), s_tdata));
    end
  end

endmodule

[verif/tb_peak_table_field_sampler_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_peak_table_field_sampler_core
// drives adds, kills, restores and samples with random stalls on both sides;
// the checker predicts every result beat and counts mismatches
// ----------------------------------------------------------------------------
module tb_peak_table_field_sampler_core;

  localparam int NPK = 16;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  int          fail_count;
  int          pending;
  bit          calm = 1'b0;

  always #10 clk = ~clk;

  peak_table_field_sampler_core #(.NPEAKS(NPK)) u_top (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata), .s_tuser(s_tuser), .m_tvalid(m_tvalid),
    .m_tready(m_tready), .m_tdata(m_tdata)
  );

  peak_field_checker #(.NPEAKS(NPK)) u_chk (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata), .s_tuser(s_tuser), .m_tvalid(m_tvalid),
    .m_tready(m_tready), .m_tdata(m_tdata), .fail_count(fail_count),
    .pending(pending)
  );

  // random receiver stalls in bursts
  initial begin
    int n;
    @(posedge clk);
    while (1) begin
      m_tready <= 1'b1;
      n = $urandom_range(1, 12);
      repeat (n) @(posedge clk);
      if (!calm && $urandom_range(0, 2) == 0) begin
        m_tready <= 1'b0;
        n = $urandom_range(1, 6);
        repeat (n) @(posedge clk);
      end
    end
  end

  task automatic send_beat(input ptfs_pkg::action_t act, input logic [15:0] ca,
                           input logic [15:0] cb,
                           input logic [15:0] wa, input logic [15:0] wb,
                           input logic [15:0] h, input logic [9:0] m, input logic [3:0] idx);
    int n;
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      n = $urandom_range(1, 6);
      repeat (n) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {6'd0, idx, m, h, wb, wa, cb, ca};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic random_beat(input ptfs_pkg::action_t act);
    logic [15:0] ca, cb, wa, wb, h;
    ca = 16'($urandom);
    cb = 16'($urandom);
    wa = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(1, 2048));
    wb = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(1, 2048));
    h = 16'($urandom);
    if ($urandom_range(0, 1)) begin
      ca = $signed(ca) >>> 6;
      cb = $signed(cb) >>> 6;
    end
    send_beat(act, ca, cb, wa, wb, h, 10'($urandom), 4'($urandom));
  endtask

  initial begin
    int act_pick;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty table, extremes, full table, bad indexes
    send_beat(ptfs_pkg::ACT_SAMPLE, 16'h0000, 16'h0000, 16'h0, 16'h0, 16'h0, 10'h0, 4'h0);
    send_beat(ptfs_pkg::ACT_KILL, 16'h0, 16'h0, 16'h1, 16'h1, 16'h0, 10'h0, 4'h0);
    send_beat(ptfs_pkg::ACT_ADD, 16'h0000, 16'h0000, 16'h0100, 16'h0100, 16'h7FFF, 10'h100,
              4'hF);
    send_beat(ptfs_pkg::ACT_ADD, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001, 16'h8000, 10'h200,
              4'h0);
    send_beat(ptfs_pkg::ACT_ADD, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 10'h1FF,
              4'h0);
    send_beat(ptfs_pkg::ACT_ADD, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 16'h7FFF, 10'h3FF,
              4'h0);
    send_beat(ptfs_pkg::ACT_SAMPLE, 16'h0000, 16'h0000, 16'h0, 16'h0, 16'h0, 10'h0, 4'h0);
    send_beat(ptfs_pkg::ACT_SAMPLE, 16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'h3FF,
              4'hF);
    send_beat(ptfs_pkg::ACT_SAMPLE, 16'h7FFF, 16'h8000, 16'h0, 16'h0, 16'h0, 10'h0, 4'h0);
    send_beat(ptfs_pkg::ACT_KILL, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 10'h0, 4'h2);
    send_beat(ptfs_pkg::ACT_KILL, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 10'h0, 4'h4);
    send_beat(ptfs_pkg::ACT_SAMPLE, 16'h0000, 16'h0000, 16'h0, 16'h0, 16'h0, 10'h0, 4'h0);
    send_beat(ptfs_pkg::ACT_RESTORE, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 10'h0, 4'h2);
    send_beat(ptfs_pkg::ACT_RESTORE, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 10'h0, 4'hF);
    for (int i = 4; i < NPK + 1; i++)
      send_beat(ptfs_pkg::ACT_ADD, 16'h0010, 16'hFFF0, 16'h0080, 16'h0080, 16'h7FFF, 10'h080,
                4'h0);
    send_beat(ptfs_pkg::ACT_SAMPLE, 16'h0010, 16'hFFF0, 16'h0, 16'h0, 16'h0, 10'h0, 4'h0);
    send_beat(ptfs_pkg::ACT_KILL, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 10'h0, 4'hF);
    send_beat(ptfs_pkg::ACT_SAMPLE, 16'h0000, 16'h0000, 16'h0, 16'h0, 16'h0, 10'h0, 4'h0);

    // hold off until every outstanding result beat has been checked
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    // random: mostly kill/restore/sample on the full table, many index values
    for (int k = 0; k < 1120; k++) begin
      if (k > 1000) calm = 1'b1;
      act_pick = $urandom_range(0, 9);
      if (act_pick < 2) random_beat(ptfs_pkg::ACT_ADD);
      else if (act_pick < 4) random_beat(ptfs_pkg::ACT_KILL);
      else if (act_pick < 6) random_beat(ptfs_pkg::ACT_RESTORE);
      else random_beat(ptfs_pkg::ACT_SAMPLE);
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #200ms;
    $display("Verification failed");
    $finish;
  end

endmodule
